@@ sv/csv_byte_tokenizer_defines.svh @@
// Assertion macros for the CSV byte tokenizer.
`ifndef CSV_BYTE_TOKENIZER_DEFINES_SVH
`define CSV_BYTE_TOKENIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define CBT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbt: assertion failed");
`define CBT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbt: assertion failed");
`else
`define CBT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CBT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/cbt_pkg.sv @@
// Types, constants and the per-character decode function of the CSV tokenizer.
package cbt_pkg;

  localparam logic [7:0] CH_BOM0  = 8'hEF;
  localparam logic [7:0] CH_BOM1  = 8'hBB;
  localparam logic [7:0] CH_BOM2  = 8'hBF;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [1:0] BOM_IDLE = 2'd0;
  localparam logic [1:0] BOM_ONE  = 2'd1;
  localparam logic [1:0] BOM_TWO  = 2'd2;
  localparam logic [1:0] BOM_DONE = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int MAX_TOKENS  = 4;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_FIELD  = 2'd1,
    KIND_RECORD = 2'd2,
    KIND_STREAM = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  ch;
  } tok_t;

  // up to four tokens caused by one input item, slot 0 goes out first
  typedef struct packed {
    logic [2:0]  cnt;
    tok_t [MAX_TOKENS-1:0] tok;
  } bundle_t;

  typedef struct packed {
    logic        quoted;
    logic        qpend;
    logic        rpend;
    logic        fempty;
    logic        lempty;
    logic [1:0]  bom;
  } st_t;

  typedef struct packed {
    logic        full;
    logic        empty;
  } q_stat_t;

  typedef struct packed {
    st_t         st;
    logic        emit;
    tok_t        tok;
  } fc_res_t;

  localparam st_t ST_RESET = '{quoted: 1'b0, qpend: 1'b0, rpend: 1'b0,
                               fempty: 1'b1, lempty: 1'b1, bom: BOM_IDLE};

  // one decoded character against the quoting state
  function automatic fc_res_t feed_char(st_t s, logic [7:0] c);
    fc_res_t r;
    logic    done;
    r          = '0;
    r.st       = s;
    r.tok.kind = KIND_CHAR;
    r.st.lempty = 1'b0;
    done       = 1'b0;
    if (s.qpend) begin
      r.st.qpend = 1'b0;
      if (c == CH_QUOTE) begin
        r.emit      = 1'b1;
        r.tok.ch    = CH_QUOTE;
        r.st.fempty = 1'b0;
        done        = 1'b1;
      end else begin
        r.st.quoted = 1'b0;
      end
    end
    if (!done) begin
      if (r.st.quoted) begin
        if (c == CH_QUOTE) begin
          r.st.qpend = 1'b1;
        end else begin
          r.emit      = 1'b1;
          r.tok.ch    = c;
          r.st.fempty = 1'b0;
        end
      end else if (c == CH_COMMA) begin
        r.emit      = 1'b1;
        r.tok.kind  = KIND_FIELD;
        r.st.fempty = 1'b1;
      end else if (c == CH_QUOTE && r.st.fempty) begin
        r.st.quoted = 1'b1;
      end else begin
        r.emit      = 1'b1;
        r.tok.ch    = c;
        r.st.fempty = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

@@ sv/cbt_front.sv @@
// Front end: accepts bytes, tracks BOM, CR and quoting state, builds token bundles.
module cbt_front
  import cbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  q_stat_t    q_stat,
  output logic       push,
  output bundle_t    push_data
);

  st_t     state_r, state_nxt;
  logic    accept;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    st_t     s;
    fc_res_t fr;
    bundle_t bd;
    logic    skip;
    s    = state_r;
    bd   = '0;
    fr   = '0;
    skip = 1'b0;
    if (in_tuser) begin
      // end of stream: flush held BOM bytes, close the record, mark the end
      if (s.bom == BOM_ONE || s.bom == BOM_TWO) begin
        fr = feed_char(s, CH_BOM0);
        s  = fr.st;
        if (fr.emit) begin
          bd.tok[bd.cnt[1:0]] = fr.tok;
          bd.cnt = bd.cnt + 3'd1;
        end
      end
      if (s.bom == BOM_TWO) begin
        fr = feed_char(s, CH_BOM1);
        s  = fr.st;
        if (fr.emit) begin
          bd.tok[bd.cnt[1:0]] = fr.tok;
          bd.cnt = bd.cnt + 3'd1;
        end
      end
      if (!s.lempty) begin
        bd.tok[bd.cnt[1:0]] = '{kind: KIND_RECORD, ch: 8'h00};
        bd.cnt = bd.cnt + 3'd1;
      end
      bd.tok[bd.cnt[1:0]] = '{kind: KIND_STREAM, ch: 8'h00};
      bd.cnt = bd.cnt + 3'd1;
      s = ST_RESET;
    end else begin
      if (s.bom != BOM_DONE) begin
        if (s.bom == BOM_IDLE && in_tdata == CH_BOM0) begin
          s.bom = BOM_ONE;
          skip  = 1'b1;
        end else if (s.bom == BOM_ONE && in_tdata == CH_BOM1) begin
          s.bom = BOM_TWO;
          skip  = 1'b1;
        end else if (s.bom == BOM_TWO && in_tdata == CH_BOM2) begin
          s.bom = BOM_DONE;
          skip  = 1'b1;
        end else begin
          // partial BOM: held bytes become ordinary characters
          if (s.bom == BOM_ONE || s.bom == BOM_TWO) begin
            fr = feed_char(s, CH_BOM0);
            s  = fr.st;
            if (fr.emit) begin
              bd.tok[bd.cnt[1:0]] = fr.tok;
              bd.cnt = bd.cnt + 3'd1;
            end
          end
          if (s.bom == BOM_TWO) begin
            fr = feed_char(s, CH_BOM1);
            s  = fr.st;
            if (fr.emit) begin
              bd.tok[bd.cnt[1:0]] = fr.tok;
              bd.cnt = bd.cnt + 3'd1;
            end
          end
          s.bom = BOM_DONE;
        end
      end
      if (!skip) begin
        if (in_tdata == CH_LF) begin
          if (!s.lempty) begin
            bd.tok[bd.cnt[1:0]] = '{kind: KIND_RECORD, ch: 8'h00};
            bd.cnt = bd.cnt + 3'd1;
          end
          s.quoted = 1'b0;
          s.qpend  = 1'b0;
          s.rpend  = 1'b0;
          s.fempty = 1'b1;
          s.lempty = 1'b1;
        end else if (in_tdata == CH_CR) begin
          // only the last CR before a line end or the stream end is dropped
          if (s.rpend) begin
            fr = feed_char(s, CH_CR);
            s  = fr.st;
            if (fr.emit) begin
              bd.tok[bd.cnt[1:0]] = fr.tok;
              bd.cnt = bd.cnt + 3'd1;
            end
          end
          s.rpend = 1'b1;
        end else begin
          if (s.rpend) begin
            s.rpend = 1'b0;
            fr = feed_char(s, CH_CR);
            s  = fr.st;
            if (fr.emit) begin
              bd.tok[bd.cnt[1:0]] = fr.tok;
              bd.cnt = bd.cnt + 3'd1;
            end
          end
          fr = feed_char(s, in_tdata);
          s  = fr.st;
          if (fr.emit) begin
            bd.tok[bd.cnt[1:0]] = fr.tok;
            bd.cnt = bd.cnt + 3'd1;
          end
        end
      end
    end
    state_nxt = accept ? s : state_r;
    push      = accept && (bd.cnt != 3'd0);
    push_data = bd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RESET;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/cbt_fifo.sv @@
// Bundle queue between front and back ends.
module cbt_fifo
  import cbt_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
)(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  input  logic    pop,
  output bundle_t head,
  output q_stat_t q_stat
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);

  bundle_t            mem_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CNT_W'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ sv/cbt_back.sv @@
// Back end: walks the head bundle one token per cycle into the output register unless out_tready stalls it.
module cbt_back
  import cbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  bundle_t    head,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [1:0] out_tuser,
  output logic       out_tlast
);

  logic        out_valid_r, out_valid_nxt;
  tok_t        tok_r, tok_nxt;
  logic        last_r, last_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        load;
  logic        at_end;

  assign load   = !q_stat.empty && (!out_valid_r || out_tready);
  assign at_end = ({1'b0, idx_r} == head.cnt - 3'd1);
  assign pop    = load && at_end;

  always_comb begin
    out_valid_nxt = out_valid_r;
    tok_nxt       = tok_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      tok_nxt       = head.tok[idx_r];
      last_nxt      = at_end;
      idx_nxt       = at_end ? 2'd0 : idx_r + 2'd1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = tok_r.ch;
  assign out_tuser  = tok_r.kind;
  assign out_tlast  = last_r;

endmodule

@@ sv/csv_byte_tokenizer.sv @@
// CSV byte tokenizer top level: front end, bundle queue and token output stage.
//
//  channel   dir  tdata            tuser            tlast
//  in_       in   data_byte[7:0]   req_type         -
//  out_      out  field_char[7:0]  token_kind[1:0]  last
//
// One byte can be accepted every cycle while the queue has room; a byte that
// yields results is queued as one bundle of up to four tokens.
// The output register sends one token per cycle while out_tready is high, so the
// sustained byte rate is one per cycle for bytes with at most one token; bytes with more tokens lower it.
// The first token of a byte passes through the queue entry and then the output register.
// rst_n (synchronous) clears decode state, queue pointers and output valid.
// in_tready drops only when the queue is full; out stalls back up through it.
`include "csv_byte_tokenizer_defines.svh"
module csv_byte_tokenizer
  import cbt_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] req_type
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] field_char
  output logic [1:0] out_tuser,  // [1:0] token_kind
  output logic       out_tlast
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  bundle_t push_data;
  bundle_t head;

  cbt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  cbt_fifo #(
    .QDEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  cbt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `CBT_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !q_stat.full)
  `CBT_ASSERT_IMP(a_stream_is_last, clk, rst_n, out_tvalid && out_tuser == KIND_STREAM, out_tlast)
  `CBT_ASSERT_IMP(a_marker_no_char, clk, rst_n, out_tvalid && out_tuser != KIND_CHAR, out_tdata == 8'h00)
  `CBT_ASSERT_NXT(a_drain, clk, rst_n, !q_stat.empty && (!out_tvalid || out_tready), out_tvalid)

endmodule

@@ test/csv_byte_tokenizer_test.sv @@
// Self-checking testbench for csv_byte_tokenizer: directed table plus random CSV streams and noise.
`timescale 1ns / 1ps
module csv_byte_tokenizer_test;
  import cbt_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DIR_ROWS = 27;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       last;
  } csv_token_t;

  // typed rows carry up to two expected tokens, other rows go to the predictor
  typedef struct packed {
    logic       req;
    logic [7:0] b;
    logic       typed;
    logic [1:0] n;
    kind_t      k0;
    logic [7:0] c0;
    kind_t      k1;
    logic [7:0] c1;
  } stim_row_t;

  typedef struct packed {
    logic       in_quotes;
    logic       quote_seen;
    logic       cr_held;
    logic       field_blank;
    logic       line_blank;
    logic [1:0] bom_seen;
  } lexer_state_t;

  localparam lexer_state_t LEX_IDLE = '{in_quotes: 1'b0, quote_seen: 1'b0, cr_held: 1'b0,
                                        field_blank: 1'b1, line_blank: 1'b1,
                                        bom_seen: BOM_IDLE};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  lexer_state_t lex = LEX_IDLE;
  csv_token_t   step_toks[$];
  csv_token_t   expected_tokens[$];
  stim_row_t    item_notes[$];
  int           fail_count = 0;
  int           sent = 0;
  int           stall_cycles = 0;
  bit           calm = 1'b0;

  stim_row_t dir_table [DIR_ROWS] = '{
    '{1'b0, 8'h61,    1'b1, 2'd1, KIND_CHAR,   8'h61, KIND_CHAR,   8'h00},
    '{1'b0, 8'h00,    1'b1, 2'd1, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, 8'hFF,    1'b1, 2'd1, KIND_CHAR,   8'hFF, KIND_CHAR,   8'h00},
    '{1'b0, CH_COMMA, 1'b1, 2'd1, KIND_FIELD,  8'h00, KIND_CHAR,   8'h00},
    '{1'b0, CH_QUOTE, 1'b1, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, 8'h78,    1'b0, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, CH_QUOTE, 1'b0, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, CH_QUOTE, 1'b0, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, CH_QUOTE, 1'b0, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, CH_COMMA, 1'b0, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, CH_CR,    1'b1, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, CH_CR,    1'b0, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, CH_LF,    1'b0, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, CH_LF,    1'b1, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, 8'h62,    1'b0, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, CH_QUOTE, 1'b0, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, CH_CR,    1'b0, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b1, 8'hA5,    1'b0, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, CH_BOM0,  1'b1, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, CH_BOM1,  1'b1, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, CH_BOM2,  1'b1, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, CH_QUOTE, 1'b0, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b1, 8'h00,    1'b1, 2'd2, KIND_RECORD, 8'h00, KIND_STREAM, 8'h00},
    '{1'b0, CH_BOM0,  1'b0, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b0, CH_BOM1,  1'b0, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b1, 8'hFF,    1'b0, 2'd0, KIND_CHAR,   8'h00, KIND_CHAR,   8'h00},
    '{1'b1, 8'h00,    1'b1, 2'd1, KIND_STREAM, 8'h00, KIND_CHAR,   8'h00}
  };

  csv_byte_tokenizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] data_byte
    .in_tuser   (in_tuser),   // [0] req_type
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] field_char
    .out_tuser  (out_tuser),  // [1:0] token_kind
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void add_token(kind_t k, logic [7:0] c);
    step_toks.insert(step_toks.size(), '{kind: k, ch: c, last: 1'b0});
  endfunction

  function automatic void add_char(logic [7:0] c);
    add_token(KIND_CHAR, c);
    lex.field_blank = 1'b0;
  endfunction

  // one decoded character against the quoting state
  function automatic void take_char(logic [7:0] c);
    lex.line_blank = 1'b0;
    if (lex.quote_seen) begin
      lex.quote_seen = 1'b0;
      if (c == CH_QUOTE) begin
        add_char(c);
        return;
      end
      lex.in_quotes = 1'b0;
    end
    if (lex.in_quotes) begin
      if (c == CH_QUOTE) lex.quote_seen = 1'b1;
      else add_char(c);
    end else if (c == CH_COMMA) begin
      add_token(KIND_FIELD, 8'h00);
      lex.field_blank = 1'b1;
    end else if (c == CH_QUOTE && lex.field_blank) begin
      lex.in_quotes = 1'b1;
    end else begin
      add_char(c);
    end
  endfunction

  // a partial BOM turns back into ordinary characters
  function automatic void release_bom();
    if (lex.bom_seen == BOM_ONE || lex.bom_seen == BOM_TWO) take_char(CH_BOM0);
    if (lex.bom_seen == BOM_TWO) take_char(CH_BOM1);
    lex.bom_seen = BOM_DONE;
  endfunction

  function automatic void close_line();
    if (!lex.line_blank) add_token(KIND_RECORD, 8'h00);
    lex.in_quotes = 1'b0;
    lex.quote_seen = 1'b0;
    lex.cr_held = 1'b0;
    lex.field_blank = 1'b1;
    lex.line_blank = 1'b1;
  endfunction

  function automatic void tokenize(logic req, logic [7:0] b);
    bit swallowed;
    swallowed = 1'b0;
    step_toks.delete();
    if (req) begin
      release_bom();
      close_line();
      add_token(KIND_STREAM, 8'h00);
      lex = LEX_IDLE;
    end else begin
      if (lex.bom_seen != BOM_DONE) begin
        if (lex.bom_seen == BOM_IDLE && b == CH_BOM0) begin
          lex.bom_seen = BOM_ONE;
          swallowed = 1'b1;
        end else if (lex.bom_seen == BOM_ONE && b == CH_BOM1) begin
          lex.bom_seen = BOM_TWO;
          swallowed = 1'b1;
        end else if (lex.bom_seen == BOM_TWO && b == CH_BOM2) begin
          lex.bom_seen = BOM_DONE;
          swallowed = 1'b1;
        end else begin
          release_bom();
        end
      end
      if (!swallowed) begin
        if (b == CH_LF) begin
          close_line();
        end else if (b == CH_CR) begin
          // only the last CR before a line end or the stream end is dropped
          if (lex.cr_held) take_char(CH_CR);
          lex.cr_held = 1'b1;
        end else begin
          if (lex.cr_held) begin
            lex.cr_held = 1'b0;
            take_char(CH_CR);
          end
          take_char(b);
        end
      end
    end
  endfunction

  function automatic stim_row_t plain_row(logic req, logic [7:0] b);
    return '{req, b, 1'b0, 2'd0, KIND_CHAR, 8'h00, KIND_CHAR, 8'h00};
  endfunction

  function automatic logic [7:0] content_byte();
    case ($urandom_range(0, 9))
      0: return CH_COMMA;
      1: return CH_CR;
      2: return CH_QUOTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 9))
      0: return CH_BOM0;
      1: return CH_BOM1;
      2: return CH_BOM2;
      3: return CH_QUOTE;
      4: return CH_COMMA;
      5: return CH_CR;
      6: return CH_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(input stim_row_t row);
    while (!calm && $urandom_range(0, 99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= row.req;
    in_tdata <= row.b;
    item_notes.insert(item_notes.size(), row);
    // ready is settled by the falling edge; the item goes in at the next rising edge
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(plain_row(1'b0, b));
  endtask

  // random file: a full, partial or no BOM, records of plain and quoted fields, stream end
  task automatic send_stream();
    int unsigned recs, flds, len, mode;
    logic [7:0] c;
    mode = $urandom_range(0, 3);
    if (mode < 2) begin
      send_byte(CH_BOM0);
      send_byte(CH_BOM1);
      send_byte(CH_BOM2);
    end else if (mode == 2) begin
      send_byte(CH_BOM0);
      if ($urandom_range(0, 1)) send_byte(CH_BOM1);
    end
    recs = $urandom_range(1, 4);
    repeat (recs) begin
      flds = $urandom_range(1, 4);
      for (int f = 0; f < flds; f++) begin
        if (f > 0) send_byte(CH_COMMA);
        len = $urandom_range(0, 5);
        if ($urandom_range(0, 9) < 4) begin
          send_byte(CH_QUOTE);
          repeat (len) begin
            c = content_byte();
            send_byte(c);
            if (c == CH_QUOTE) send_byte(c);
          end
          send_byte(CH_QUOTE);
        end else begin
          repeat (len) send_byte(content_byte());
        end
      end
      case ($urandom_range(0, 3))
        0: send_byte(CH_LF);
        1: begin
          send_byte(CH_CR);
          send_byte(CH_LF);
        end
        2: begin
          send_byte(CH_CR);
          send_byte(CH_CR);
          send_byte(CH_LF);
        end
        default: begin
          send_byte(CH_LF);
          send_byte(CH_LF);
        end
      endcase
    end
    if ($urandom_range(0, 3) == 0) send_byte(CH_CR);
    send_item(plain_row(1'b1, 8'($urandom_range(0, 255))));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8)) begin
      if ($urandom_range(0, 9) == 0) send_item(plain_row(1'b1, 8'($urandom_range(0, 255))));
      else send_byte(noise_byte());
    end
  endtask

  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(0, 99) >= 36);
  end

  // handshakes sampled on the falling edge, stable until the accepting rising edge
  always @(negedge clk) begin
    stim_row_t  note;
    csv_token_t want;
    if (rst_n && in_tvalid && in_tready) begin
      note = item_notes.pop_front();
      tokenize(note.req, note.b);
      if (note.typed) begin
        step_toks.delete();
        if (note.n > 0) add_token(note.k0, note.c0);
        if (note.n > 1) add_token(note.k1, note.c1);
      end
      if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
      foreach (step_toks[i]) expected_tokens.insert(expected_tokens.size(), step_toks[i]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token: kind %0d char %02h last %0b", out_tuser, out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (out_tuser !== want.kind) begin
          $error("token_kind: expected %0d, got %0d", want.kind, out_tuser);
          fail_count++;
        end
        if (out_tdata !== want.ch) begin
          $error("field_char: expected %02h, got %02h", want.ch, out_tdata);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_tlast);
          fail_count++;
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DIR_ROWS; i++) send_item(dir_table[i]);
    while (sent < DIR_ROWS + RANDOM_ITEMS) begin
      calm = (sent >= 200 && sent < 280);
      if ($urandom_range(0, 4) != 0) send_stream();
      else send_noise();
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0 || item_notes.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
